FILE: sv/rcbd_pkg.sv
// Shared types and byte codes for the remote command byte decoder.
package rcbd_pkg;

	// Fixed field widths and the default buffer depth
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CountW = 7;
	localparam int unsigned ValueW = 32;
	localparam int unsigned DefBufferDepth = 64;

	// Received byte codes
	localparam logic [ByteW-1:0] ByteSpin     = 8'h4B;
	localparam logic [ByteW-1:0] ByteSteerI   = 8'h49;
	localparam logic [ByteW-1:0] ByteSteerJ   = 8'h4A;
	localparam logic [ByteW-1:0] ByteOpen     = 8'h7B;
	localparam logic [ByteW-1:0] ByteClose    = 8'h7D;
	localparam logic [ByteW-1:0] ByteReport   = 8'h50;
	localparam logic [ByteW-1:0] ByteFlash    = 8'h57;
	localparam logic [ByteW-1:0] ByteHash     = 8'h23;
	localparam logic [ByteW-1:0] ByteDirBase  = 8'h40;
	localparam logic [ByteW-1:0] ByteZero     = 8'h30;
	localparam logic [ByteW-1:0] ByteRight    = 8'h43;
	localparam logic [ByteW-1:0] ByteLeft     = 8'h47;
	localparam logic [ByteW-1:0] ByteSpeedLo  = 8'h31;
	localparam logic [ByteW-1:0] ByteSpeedHi  = 8'h35;
	localparam logic [ByteW-1:0] ByteDirLo    = 8'h41;
	localparam logic [ByteW-1:0] ByteDirHi    = 8'h48;
	localparam logic [ByteW-1:0] ByteDirE     = 8'h45;
	localparam logic [ByteW-1:0] ByteSelHi    = 8'h36;
	localparam logic [ByteW-1:0] ByteRawDirHi = 8'h08;

	// Turn mode codes
	localparam logic [1:0] TurnSteer = 2'd0;
	localparam logic [1:0] TurnSpin  = 2'd1;
	localparam logic [1:0] TurnSpeed = 2'd2;

	// Parameter index of the velocity set point
	localparam logic [2:0] ParamVelocity = 3'd0;

	// Speed step per digit level
	localparam logic [ValueW-1:0] SpeedStep = 32'd6;

	// Decoder state carried from byte to byte
	typedef struct packed {
		logic [1:0]        turn;
		logic [3:0]        dir;
		logic              left;
		logic              right;
		logic              collecting;
		logic [CountW-1:0] count;
		logic [ByteW-1:0]  selector;
		logic [ByteW-1:0]  command;
		logic [ValueW-1:0] acc;
	} rcbd_state_t;

	// One decoded result
	typedef struct packed {
		logic [1:0]        turn_mode;
		logic [3:0]        direction;
		logic              turn_left;
		logic              turn_right;
		logic              param_write;
		logic [2:0]        param_index;
		logic [ValueW-1:0] param_value;
		logic              report_request;
		logic              flash_request;
	} rcbd_result_t;

endpackage

FILE: sv/rcbd_decode.sv
// Combinational decode of one received byte against the current decoder state.
module rcbd_decode #(
	parameter int unsigned BUFFER_DEPTH = rcbd_pkg::DefBufferDepth
) (
	input  logic [rcbd_pkg::ByteW-1:0] rx_byte,
	input  logic                       position_mode,
	input  rcbd_pkg::rcbd_state_t      cur,
	output rcbd_pkg::rcbd_state_t      nxt,
	output rcbd_pkg::rcbd_result_t     res
);
	import rcbd_pkg::*;

	// Clamp a 37-bit signed value to signed 32 bit
	function automatic logic [ValueW-1:0] sat32(input logic [36:0] v);
		logic [ValueW-1:0] r;
		if (v[36:31] == 6'b000000 || v[36:31] == 6'b111111) begin
			r = v[31:0];
		end else if (v[36]) begin
			r = {1'b1, {(ValueW-1){1'b0}}};
		end else begin
			r = {1'b0, {(ValueW-1){1'b1}}};
		end
		return r;
	endfunction

	logic [36:0]       acc_ext;
	logic [36:0]       acc_x10;
	logic [ValueW-1:0] acc_sat;
	logic [36:0]       acc_sum;
	logic [ValueW-1:0] acc_new;
	logic [CountW-1:0] depth_lim;

	// Horner step: sat(sat(acc * 10) + (byte - '0'))
	always_comb begin
		acc_ext = {{5{cur.acc[ValueW-1]}}, cur.acc};
		acc_x10 = (acc_ext << 3) + (acc_ext << 1);
		acc_sat = sat32(acc_x10);
		acc_sum = {{5{acc_sat[ValueW-1]}}, acc_sat} + {29'd0, rx_byte}
			- {29'd0, ByteZero};
		acc_new = sat32(acc_sum);
	end

	assign depth_lim = CountW'(BUFFER_DEPTH);

	// Decode turn mode, direction, flags and frame
	always_comb begin
		nxt = cur;
		res = '0;

		priority if (rx_byte == ByteSpin) begin
			nxt.turn = TurnSpin;
		end else if (rx_byte == ByteSteerI || rx_byte == ByteSteerJ) begin
			nxt.turn = TurnSteer;
		end else if (rx_byte >= ByteSpeedLo && rx_byte <= ByteSpeedHi) begin
			nxt.turn = TurnSpeed;
			res.param_write = 1'b1;
			res.param_index = ParamVelocity;
			res.param_value = ValueW'(rx_byte[2:0]) * SpeedStep;
		end else begin
			nxt.turn = cur.turn;
		end

		// Direction and turn flags in speed control mode
		if (!position_mode) begin
			priority if (nxt.turn == TurnSteer) begin
				priority if (rx_byte >= ByteDirLo && rx_byte <= ByteDirHi) begin
					nxt.dir = 4'(rx_byte - ByteDirBase);
				end else if (rx_byte <= ByteRawDirHi) begin
					nxt.dir = rx_byte[3:0];
				end else begin
					nxt.dir = 4'd0;
				end
			end else if (nxt.turn == TurnSpin) begin
				nxt.left  = (rx_byte == ByteLeft);
				nxt.right = (rx_byte == ByteRight);
				if (rx_byte == ByteDirLo || rx_byte == ByteDirE) begin
					nxt.dir = 4'(rx_byte - ByteDirBase);
				end else begin
					nxt.dir = 4'd0;
				end
			end else begin
				nxt.dir = cur.dir;
			end
		end

		if (rx_byte == ByteOpen) begin
			nxt.collecting = 1'b1;
		end

		// Close the frame or store a frame byte
		if (rx_byte == ByteClose) begin
			priority if (cur.command == ByteReport) begin
				res.report_request = 1'b1;
			end else if (cur.command == ByteFlash) begin
				res.flash_request = 1'b1;
			end else if (cur.selector != ByteHash && cur.selector >= ByteZero
				&& cur.selector <= ByteSelHi) begin
				res.param_write = 1'b1;
				res.param_index = cur.selector[2:0];
				res.param_value = cur.acc;
			end else begin
				res.param_write = res.param_write;
			end
			nxt.collecting = 1'b0;
			nxt.count      = '0;
			nxt.selector   = '0;
			nxt.command    = '0;
			nxt.acc        = '0;
		end else if (nxt.collecting && cur.count < depth_lim) begin
			if (cur.count == CountW'(1)) begin
				nxt.selector = rx_byte;
			end
			if (cur.count == CountW'(3)) begin
				nxt.command = rx_byte;
			end
			if (cur.count >= CountW'(3)) begin
				nxt.acc = acc_new;
			end
			nxt.count = cur.count + CountW'(1);
		end

		res.turn_mode  = nxt.turn;
		res.direction  = nxt.dir;
		res.turn_left  = nxt.left;
		res.turn_right = nxt.right;
	end

endmodule

FILE: sv/remote_command_byte_decoder_top.sv
// Top level of the remote command byte decoder: input stage, decode, result register.
//
// Input channel: in_valid / in_stall with rx_byte, one received byte per
// transaction. Output channel: out_valid / out_stall with the decoded fields,
// exactly one result transaction per input transaction, in order.
// Configuration: cfg_write_en writes cfg_write_data into position_mode.
//
// A byte accepted into the input stage is decoded combinationally against the
// running state and is loaded into the result register once that register is
// free. Throughput is one byte per cycle while the receiver does not stall;
// the combinational decode in front of the result register sets that figure.
// When the receiver stalls, the result register holds, the input stage fills
// and then in_stall rises; no transaction is lost or repeated.
// Reset clears turn, direction, flag and frame state, position_mode and both
// valid bits.
module remote_command_byte_decoder_top #(
	parameter int unsigned BUFFER_DEPTH = rcbd_pkg::DefBufferDepth
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rcbd_pkg::ByteW-1:0]  rx_byte,
	input  logic                        cfg_write_en,
	input  logic                        cfg_write_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  turn_mode,
	output logic [3:0]                  direction,
	output logic                        turn_left,
	output logic                        turn_right,
	output logic                        param_write,
	output logic [2:0]                  param_index,
	output logic signed [rcbd_pkg::ValueW-1:0] param_value,
	output logic                        report_request,
	output logic                        flash_request
);
	import rcbd_pkg::*;

	logic              valid_s1;
	logic [ByteW-1:0]  byte_s1;
	logic              out_valid_q;
	rcbd_result_t      result_q;
	rcbd_state_t       state_q;
	rcbd_state_t       state_nxt;
	rcbd_result_t      result_nxt;
	logic              pos_mode_q;
	logic              out_free;
	logic              advance;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_mode_q <= 1'b0;
		end else if (cfg_write_en) begin
			pos_mode_q <= cfg_write_data;
		end
	end

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	rcbd_decode #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) u_decode (
		.rx_byte      (byte_s1),
		.position_mode(pos_mode_q),
		.cur          (state_q),
		.nxt          (state_nxt),
		.res          (result_nxt)
	);

	// Advance the running state with each decoded byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register; drop valid once the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign turn_mode      = result_q.turn_mode;
	assign direction      = result_q.direction;
	assign turn_left      = result_q.turn_left;
	assign turn_right     = result_q.turn_right;
	assign param_write    = result_q.param_write;
	assign param_index    = result_q.param_index;
	assign param_value    = result_q.param_value;
	assign report_request = result_q.report_request;
	assign flash_request  = result_q.flash_request;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the remote command byte decoder: random byte stream with idling.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rcbd_pkg::*;

	localparam int BufferDepth = DefBufferDepth;
	localparam int CycleLimit  = 400000;
	localparam int RandomPhases = 8;
	localparam int PhaseItems   = 100;
	localparam int DrainCycles  = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [ByteW-1:0] rx_byte = '0;
	logic cfg_write_en = 1'b0;
	logic cfg_write_data = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] turn_mode;
	logic [3:0] direction;
	logic turn_left;
	logic turn_right;
	logic param_write;
	logic [2:0] param_index;
	logic signed [ValueW-1:0] param_value;
	logic report_request;
	logic flash_request;

	remote_command_byte_decoder_top #(
		.BUFFER_DEPTH(BufferDepth)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.cfg_write_en(cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.turn_mode(turn_mode),
		.direction(direction),
		.turn_left(turn_left),
		.turn_right(turn_right),
		.param_write(param_write),
		.param_index(param_index),
		.param_value(param_value),
		.report_request(report_request),
		.flash_request(flash_request)
	);

	// Mirror of the decoder state
	logic                     pos_mode = 1'b0;
	logic [1:0]               turn_q = TurnSteer;
	logic [3:0]               dir_q = '0;
	logic                     left_q = 1'b0;
	logic                     right_q = 1'b0;
	logic                     in_frame = 1'b0;
	logic [CountW-1:0]        frame_len = '0;
	logic [ByteW-1:0]         sel_byte = '0;
	logic [ByteW-1:0]         cmd_byte = '0;
	logic signed [ValueW-1:0] frame_sum = '0;

	// Stimulus and expectation stores
	logic [ByteW-1:0] pending_bytes[$];
	rcbd_result_t     decoded_due[$];
	int queued_total = 0;
	int accepted_total = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int src_gap_odds = 0;
	int sink_stall_odds = 0;
	int src_gap_left = 0;
	int sink_stall_left = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic signed [ValueW-1:0] clamp_to_int32(input longint v);
		if (v > longint'(32'sh7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		if (v < -longint'(32'sh7FFF_FFFF) - 1)
			return 32'sh8000_0000;
		return v[ValueW-1:0];
	endfunction

	// Advance the mirrored state by one byte and return the decoded result
	function automatic rcbd_result_t decode_byte(input logic [ByteW-1:0] b);
		rcbd_result_t r;
		longint scaled;
		r = '0;
		if (b == ByteSpin)
			turn_q = TurnSpin;
		else if (b == ByteSteerI || b == ByteSteerJ)
			turn_q = TurnSteer;
		else if (b >= ByteSpeedLo && b <= ByteSpeedHi) begin
			turn_q = TurnSpeed;
			r.param_write = 1'b1;
			r.param_index = ParamVelocity;
			r.param_value = SpeedStep * ValueW'(b - ByteZero);
		end

		// Direction and flags only in speed control mode
		if (!pos_mode) begin
			if (turn_q == TurnSteer) begin
				if (b >= ByteDirLo && b <= ByteDirHi)
					dir_q = 4'(b - ByteDirBase);
				else if (b <= ByteRawDirHi)
					dir_q = b[3:0];
				else
					dir_q = 4'd0;
			end else if (turn_q == TurnSpin) begin
				left_q = (b == ByteLeft);
				right_q = (b == ByteRight);
				dir_q = (b == ByteDirLo || b == ByteDirE) ? 4'(b - ByteDirBase) : 4'd0;
			end
		end

		if (b == ByteOpen)
			in_frame = 1'b1;

		// Close the frame, or store and accumulate the byte
		if (b == ByteClose) begin
			if (cmd_byte == ByteReport)
				r.report_request = 1'b1;
			else if (cmd_byte == ByteFlash)
				r.flash_request = 1'b1;
			else if (sel_byte != ByteHash && sel_byte >= ByteZero && sel_byte <= ByteSelHi) begin
				r.param_write = 1'b1;
				r.param_index = 3'(sel_byte - ByteZero);
				r.param_value = frame_sum;
			end
			in_frame = 1'b0;
			frame_len = '0;
			sel_byte = '0;
			cmd_byte = '0;
			frame_sum = '0;
		end else if (in_frame && frame_len < BufferDepth) begin
			if (frame_len == 1)
				sel_byte = b;
			if (frame_len == 3)
				cmd_byte = b;
			if (frame_len >= 3) begin
				scaled = clamp_to_int32(longint'(frame_sum) * 10);
				frame_sum = clamp_to_int32(scaled + longint'(b) - 48);
			end
			frame_len = frame_len + 1'b1;
		end

		r.turn_mode = turn_q;
		r.direction = dir_q;
		r.turn_left = left_q;
		r.turn_right = right_q;
		return r;
	endfunction

	function automatic void check_field(input string label, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, label, want, got);
			mismatch_count++;
		end
	endfunction

	// Driver: predict each accepted transaction, then present the next byte or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decoded_due.push_back(decode_byte(rx_byte));
				accepted_total++;
			end
			if (!in_valid || !in_stall) begin
				if (src_gap_left > 0) begin
					src_gap_left--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() == 0) begin
					in_valid <= 1'b0;
				end else if (src_gap_odds != 0 && $urandom_range(1, src_gap_odds) == 1) begin
					src_gap_left = $urandom_range(0, 14);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					rx_byte <= pending_bytes.pop_front();
				end
			end
		end
	end

	// Monitor: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		rcbd_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (decoded_due.size() == 0) begin
					$display("%0t: unexpected result transaction", $time);
					mismatch_count++;
				end else begin
					want = decoded_due.pop_front();
					check_field("turn_mode", want.turn_mode, turn_mode);
					check_field("direction", want.direction, direction);
					check_field("turn_left", want.turn_left, turn_left);
					check_field("turn_right", want.turn_right, turn_right);
					check_field("param_write", want.param_write, param_write);
					check_field("param_index", want.param_index, param_index);
					check_field("param_value", want.param_value, param_value);
					check_field("report_request", want.report_request, report_request);
					check_field("flash_request", want.flash_request, flash_request);
				end
			end
			if (sink_stall_left > 0) begin
				sink_stall_left--;
				out_stall <= 1'b1;
			end else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1) begin
				sink_stall_left = $urandom_range(0, 14);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("FAIL remote_command_byte_decoder_top");
			$finish;
		end
	end

	task automatic push_byte(input logic [ByteW-1:0] b);
		pending_bytes.push_back(b);
		queued_total++;
	endtask

	task automatic push_digits(input int n);
		repeat (n) push_byte(ByteZero + ByteW'($urandom_range(0, 9)));
	endtask

	// Queue one frame with random content; a few lose their close
	task automatic push_frame();
		int kind;
		int pick;
		kind = $urandom_range(0, 9);
		pick = $urandom_range(0, 9);
		push_byte(ByteOpen);
		if (pick < 7)
			push_byte(ByteZero + ByteW'($urandom_range(0, 6)));
		else if (pick == 7)
			push_byte(ByteHash);
		else if (pick == 8)
			push_byte(ByteZero + ByteW'($urandom_range(7, 8)));
		else
			push_byte(ByteW'($urandom_range(0, 255)));
		push_byte(ByteW'($urandom_range(0, 255)));
		case (kind)
			0: begin
				push_byte(ByteReport);
				push_digits($urandom_range(0, 3));
			end
			1: begin
				push_byte(ByteFlash);
				push_digits($urandom_range(0, 3));
			end
			7: repeat ($urandom_range(1, 6)) push_byte(ByteW'($urandom_range(0, 255)));
			8: repeat ($urandom_range(1, 12)) push_byte(ByteW'($urandom_range(0, 8'h2F)));
			9: push_digits($urandom_range(BufferDepth - 4, BufferDepth + 12));
			default: push_digits($urandom_range(1, 12));
		endcase
		if ($urandom_range(0, 9) != 0)
			push_byte(ByteClose);
	endtask

	// Queue a short burst of steering commands or raw bytes
	task automatic push_noise();
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 5))
				0: push_byte(ByteSpin);
				1: push_byte($urandom_range(0, 1) ? ByteSteerI : ByteSteerJ);
				2: push_byte(ByteSpeedLo + ByteW'($urandom_range(0, 4)));
				3: push_byte(ByteDirBase + ByteW'($urandom_range(0, 9)));
				4: push_byte(ByteW'($urandom_range(0, 9)));
				default: push_byte(ByteW'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (accepted_total != queued_total || decoded_due.size() != 0);
	endtask

	task automatic write_position_mode(input logic v);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		pos_mode = v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	// Reset, directed bytes, then random phases under changing settings
	initial begin
		logic [ByteW-1:0] directed[$];
		logic next_mode;
		int phase_end;
		int odds;
		directed = '{ByteSpin, ByteLeft, ByteRight, ByteDirE, 8'hFF, ByteSteerI, ByteRawDirHi,
			8'h00, ByteSteerJ, ByteSpeedLo, ByteSpeedHi, ByteClose,
			ByteOpen, "3", "x", ByteReport, ByteClose,
			ByteOpen, ByteHash, ".", ByteFlash, ByteClose,
			ByteOpen, ByteSelHi, ".", "9", ByteClose};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		write_position_mode(1'b0);

		src_gap_odds = 4;
		sink_stall_odds = 4;
		foreach (directed[i])
			push_byte(directed[i]);
		wait_drained();

		for (int phase = 0; phase < RandomPhases; phase++) begin
			next_mode = (phase < 2) ? (phase == 0) : 1'($urandom_range(0, 1));
			write_position_mode(next_mode);
			odds = $urandom_range(0, 3);
			src_gap_odds = (phase == RandomPhases - 1 || odds[0]) ? 0 : $urandom_range(3, 8);
			sink_stall_odds = (phase == RandomPhases - 1 || odds[1]) ? 0 : $urandom_range(3, 8);
			phase_end = queued_total + PhaseItems;
			while (queued_total < phase_end) begin
				if ($urandom_range(0, 9) < 6)
					push_frame();
				else
					push_noise();
			end
			wait_drained();
		end

		repeat (DrainCycles) @(posedge clk);
		if (mismatch_count == 0 && decoded_due.size() == 0)
			$display("PASS remote_command_byte_decoder_top");
		else
			$display("FAIL remote_command_byte_decoder_top");
		$finish;
	end

endmodule
